/* hw/rtl/qspc_pkg.sv */
// qspc_pkg: shared types, codes and constants of the quadrature speed PID controller.
// No dependencies; imported by qspc_front, qspc_fifo, qspc_back, the top level and the testbench.
package qspc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [15:0] GAIN_RESET  = 16'sd1024;
	localparam logic [9:0]         PWM_RESET   = 10'd1000;
	localparam logic [12:0]        ILIM_RESET  = 13'd5000;

	typedef enum logic {
		CMD_ENC  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_RUN   = 2'd0,
		MODE_HOLD  = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_COAST = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		DRV_KEEP  = 3'd0,
		DRV_FWD   = 3'd1,
		DRV_BWD   = 3'd2,
		DRV_BRAKE = 3'd3,
		DRV_COAST = 3'd4
	} drive_t;

	typedef enum logic [2:0] {
		CFG_GAIN_P = 3'd0,
		CFG_GAIN_I = 3'd1,
		CFG_GAIN_D = 3'd2,
		CFG_PWM    = 3'd3,
		CFG_ILIM   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [9:0]         pwm_top;
		logic [12:0]        integral_limit;
	} cfg_t;

	// one regulation tick, classified by the front end
	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] speed;
		logic signed [15:0] err;
		logic signed [15:0] dv;
		logic signed [13:0] isum_old;
		logic signed [13:0] isum_new;
	} tick_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* hw/rtl/qspc_item_if.sv */
// qspc_item_if: input channel (encoder samples and regulation ticks).
// Depends on nothing.
interface qspc_item_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic               enc_a;
	logic               enc_b;
	logic signed [15:0] setpoint;
	logic [1:0]         mode;

	modport source (output valid, cmd, enc_a, enc_b, setpoint, mode, input ready);
	modport sink   (input valid, cmd, enc_a, enc_b, setpoint, mode, output ready);
endinterface

/* hw/rtl/qspc_result_if.sv */
// qspc_result_if: result channel, one transfer per regulation tick.
// Depends on nothing.
interface qspc_result_if;
	logic               valid;
	logic               ready;
	logic [9:0]         duty;
	logic [2:0]         drive;
	logic signed [15:0] speed;
	logic signed [15:0] speed_error;
	logic signed [13:0] integral;

	modport source (output valid, duty, drive, speed, speed_error, integral, input ready);
	modport sink   (input valid, duty, drive, speed, speed_error, integral, output ready);
endinterface

/* hw/rtl/qspc_front.sv */
// qspc_front: accepts items, counts x4 quadrature position, classifies ticks.
// Computes speed, error, speed change and the clamped integral. Uses qspc_pkg.
module qspc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	qspc_item_if.sink            item,
	input  logic [12:0]          integral_limit,
	input  logic                 fifo_full,
	output logic                 push,
	output qspc_pkg::tick_t      entry
);
	import qspc_pkg::*;

	logic [COUNT_WIDTH-1:0] position_q;
	logic [15:0]            last_pos_q;
	logic signed [15:0]     prev_speed_q;
	logic signed [15:0]     held_q;
	logic signed [13:0]     isum_q;
	logic                   prev_a_q;
	logic                   prev_b_q;

	logic                   accept;
	logic                   is_tick;
	logic                   is_run;
	logic signed [2:0]      step_a;
	logic signed [2:0]      step_b;
	logic signed [2:0]      step;
	logic signed [15:0]     speed;
	logic signed [15:0]     err;
	logic signed [15:0]     dv;
	logic signed [16:0]     sum;
	logic signed [16:0]     lim;
	logic signed [16:0]     nlim;
	logic signed [13:0]     isum_clamp;

	assign item.ready = !fifo_full;
	assign accept     = item.valid && item.ready;
	assign is_tick    = (cmd_t'(item.cmd) == CMD_TICK);
	assign is_run     = (mode_t'(item.mode) == MODE_RUN);

	always_comb begin
		step_a = 3'sd0;
		step_b = 3'sd0;
		if (item.enc_a != prev_a_q) begin
			step_a = (item.enc_a == item.enc_b) ? 3'sd1 : -3'sd1;
		end
		if (item.enc_b != prev_b_q) begin
			step_b = (item.enc_a != item.enc_b) ? 3'sd1 : -3'sd1;
		end
		step = step_a + step_b;
	end

	always_comb begin
		speed = signed'(position_q[15:0] - last_pos_q);
		err   = item.setpoint - speed;
		dv    = speed - prev_speed_q;
		sum   = {{3{isum_q[13]}}, isum_q} + {err[15], err};
		lim   = signed'({4'b0, integral_limit});
		nlim  = -lim;
		priority if (sum > lim) begin
			isum_clamp = lim[13:0];
		end else if (sum < nlim) begin
			isum_clamp = nlim[13:0];
		end else begin
			isum_clamp = sum[13:0];
		end
	end

	always_comb begin
		push           = accept && is_tick;
		entry.mode     = mode_t'(item.mode);
		entry.speed    = speed;
		entry.err      = is_run ? err : held_q;
		entry.dv       = dv;
		entry.isum_old = isum_q;
		entry.isum_new = is_run ? isum_clamp : isum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			last_pos_q   <= '0;
			prev_speed_q <= '0;
			held_q       <= '0;
			isum_q       <= '0;
			prev_a_q     <= 1'b0;
			prev_b_q     <= 1'b0;
		end else if (accept) begin
			if (!is_tick) begin
				position_q <= position_q + {{(COUNT_WIDTH-3){step[2]}}, step};
				prev_a_q   <= item.enc_a;
				prev_b_q   <= item.enc_b;
			end else begin
				last_pos_q <= position_q[15:0];
				if (is_run) begin
					prev_speed_q <= speed;
					held_q       <= err;
					isum_q       <= isum_clamp;
				end
			end
		end
	end

endmodule

/* hw/rtl/qspc_fifo.sv */
// qspc_fifo: short tick queue between the front end and the PID back end.
// Uses qspc_pkg.
module qspc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qspc_pkg::tick_t      wr_entry,
	input  logic                 pop,
	output qspc_pkg::tick_t      rd_entry,
	output qspc_pkg::fifo_stat_t stat
);
	import qspc_pkg::*;

	tick_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

endmodule

/* hw/rtl/qspc_back.sv */
// qspc_back: PID datapath; products, sum, scale/saturate, mode handling, output register.
// Uses qspc_pkg and qspc_result_if.
module qspc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qspc_pkg::cfg_t       cfg,
	input  qspc_pkg::tick_t      head,
	input  logic                 head_valid,
	output logic                 pop,
	qspc_result_if.source        result
);
	import qspc_pkg::*;

	logic                adv;

	logic                v_s1;
	mode_t               mode_s1;
	logic signed [15:0]  speed_s1;
	logic signed [15:0]  err_s1;
	logic signed [13:0]  isum_s1;
	logic signed [31:0]  prod_p_s1;
	logic signed [29:0]  prod_i_s1;
	logic signed [31:0]  prod_d_s1;

	logic                v_s2;
	mode_t               mode_s2;
	logic signed [15:0]  speed_s2;
	logic signed [15:0]  err_s2;
	logic signed [13:0]  isum_s2;
	logic signed [33:0]  acc_s2;

	logic [9:0]          drive_level_q;
	logic                out_valid_q;
	logic [9:0]          duty_q;
	drive_t              drive_q;
	logic signed [15:0]  speed_q;
	logic signed [15:0]  err_q;
	logic signed [13:0]  isum_q;

	logic signed [33:0]  shr;
	logic signed [25:0]  act26;
	logic signed [15:0]  act16;
	logic signed [16:0]  act17;
	logic [16:0]         mag;
	logic [9:0]          duty_run;
	logic [9:0]          lvl;
	drive_t              drv;

	assign adv = !out_valid_q || result.ready;
	assign pop = adv && head_valid;

	always_comb begin
		shr   = acc_s2 >>> 8;
		act26 = shr[25:0] + {25'b0, (acc_s2[33] && (acc_s2[7:0] != 8'd0))};
		priority if (act26 > 26'sd32767) begin
			act16 = 16'sh7fff;
		end else if (act26 < -26'sd32768) begin
			act16 = 16'sh8000;
		end else begin
			act16 = act26[15:0];
		end
		act17    = {act16[15], act16};
		mag      = act16[15] ? unsigned'(-act17) : unsigned'(act17);
		duty_run = (mag > {7'b0, cfg.pwm_top}) ? cfg.pwm_top : mag[9:0];
		unique case (mode_s2)
			MODE_RUN: begin
				lvl = duty_run;
				drv = (act16 > 16'sd0) ? DRV_FWD : DRV_BWD;
			end
			MODE_HOLD: begin
				lvl = drive_level_q;
				drv = DRV_KEEP;
			end
			MODE_STOP: begin
				lvl = cfg.pwm_top;
				drv = DRV_BRAKE;
			end
			default: begin
				lvl = '0;
				drv = DRV_COAST;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1   <= head.mode;
			speed_s1  <= head.speed;
			err_s1    <= head.err;
			isum_s1   <= head.isum_new;
			prod_p_s1 <= cfg.gain_p * head.err;
			prod_i_s1 <= cfg.gain_i * head.isum_old;
			prod_d_s1 <= cfg.gain_d * head.dv;

			mode_s2   <= mode_s1;
			speed_s2  <= speed_s1;
			err_s2    <= err_s1;
			isum_s2   <= isum_s1;
			acc_s2    <= 34'(prod_p_s1) + 34'(prod_i_s1) - 34'(prod_d_s1);

			duty_q    <= lvl;
			drive_q   <= drv;
			speed_q   <= speed_s2;
			err_q     <= err_s2;
			isum_q    <= isum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
			drive_level_q <= '0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (v_s2) begin
				drive_level_q <= lvl;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.duty        = duty_q;
	assign result.drive       = drive_q;
	assign result.speed       = speed_q;
	assign result.speed_error = err_q;
	assign result.integral    = isum_q;

endmodule

/* hw/rtl/quadrature_speed_pid_motor_controller.sv */
// quadrature_speed_pid_motor_controller: top level, configuration registers and assertions.
// Uses qspc_pkg, qspc_item_if, qspc_result_if, qspc_front, qspc_fifo, qspc_back.
//
//  channel  | dir | transfer carries
//  ---------+-----+--------------------------------------------------
//  item     | in  | cmd, enc_a, enc_b, setpoint, mode
//  result   | out | duty, drive, speed, speed_error, integral
//  cfg      | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// One item per cycle while the tick queue is not full. Encoder samples finish in the cycle they are taken.
// A tick's result passes the tick queue, the product stage, the sum stage and the
// output register; it is valid once it reaches the output register.
// A stalled result holds the back end; the front keeps taking items until
// the 4-entry tick queue is full. Reset is asynchronous and needs no sweep.
module quadrature_speed_pid_motor_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	qspc_item_if.sink   item,
	qspc_result_if.source result
);
	import qspc_pkg::*;

	cfg_t       cfg_q;
	tick_t      wr_entry;
	tick_t      rd_entry;
	fifo_stat_t stat;
	logic       push;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= GAIN_RESET;
			cfg_q.gain_i         <= GAIN_RESET;
			cfg_q.gain_d         <= GAIN_RESET;
			cfg_q.pwm_top        <= PWM_RESET;
			cfg_q.integral_limit <= ILIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_GAIN_P: cfg_q.gain_p         <= signed'(cfg_data);
				CFG_GAIN_I: cfg_q.gain_i         <= signed'(cfg_data);
				CFG_GAIN_D: cfg_q.gain_d         <= signed'(cfg_data);
				CFG_PWM:    cfg_q.pwm_top        <= cfg_data[9:0];
				CFG_ILIM:   cfg_q.integral_limit <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	qspc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.integral_limit (cfg_q.integral_limit),
		.fifo_full      (stat.full),
		.push           (push),
		.entry          (wr_entry)
	);

	qspc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (stat)
	);

	qspc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (rd_entry),
		.head_valid (!stat.empty),
		.pop        (pop),
		.result     (result)
	);

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("tick queue full and empty at once");

	a_coast_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive == DRV_COAST) |-> (result.duty == 10'd0))
		else $error("coast with nonzero duty");

	a_brake_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive == DRV_BRAKE) |-> (result.duty == cfg_q.pwm_top))
		else $error("brake duty differs from pwm top");

	a_run_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.drive == DRV_FWD || result.drive == DRV_BWD))
		|-> (result.duty <= cfg_q.pwm_top))
		else $error("running duty above pwm top");

endmodule

/* tb/sv/quadrature_speed_pid_motor_controller_tb.sv */
// quadrature_speed_pid_motor_controller_tb: self-checking testbench for the speed PID controller.
// Directed and random encoder/tick traffic is checked against an in-bench predictor.
// Depends on qspc_pkg, qspc_item_if, qspc_result_if and the controller RTL.
`timescale 1ns / 100ps

module quadrature_speed_pid_motor_controller_tb;
	import qspc_pkg::*;

	localparam int QUIET_LIMIT = 3000;

	typedef struct {
		logic [9:0]         duty;
		drive_t             drive;
		logic signed [15:0] speed;
		logic signed [15:0] speed_error;
		logic signed [13:0] integral;
	} tick_result_t;

	// predictor of the controller plus the queue of results still owed by it
	class speed_loop_scoreboard;
		logic signed [15:0]     gain_p, gain_i, gain_d;
		logic [9:0]             pwm_top;
		logic [12:0]            integral_limit;
		logic [COUNT_WIDTH-1:0] position, last_position;
		logic signed [15:0]     prev_speed, held_error;
		logic signed [13:0]     error_sum;
		logic [9:0]             drive_level;
		logic                   prev_a, prev_b;
		tick_result_t           owed[$];
		int                     errors;

		function new();
			gain_p = GAIN_RESET;
			gain_i = GAIN_RESET;
			gain_d = GAIN_RESET;
			pwm_top = PWM_RESET;
			integral_limit = ILIM_RESET;
			position = '0;
			last_position = '0;
			prev_speed = '0;
			held_error = '0;
			error_sum = '0;
			drive_level = '0;
			prev_a = 1'b0;
			prev_b = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				CFG_GAIN_P: gain_p = val;
				CFG_GAIN_I: gain_i = val;
				CFG_GAIN_D: gain_d = val;
				CFG_PWM:    pwm_top = val[9:0];
				CFG_ILIM:   integral_limit = val[12:0];
				default: ;
			endcase
		endfunction

		function void note_item(cmd_t cmd, logic a, logic b, logic signed [15:0] setpoint,
				mode_t mode);
			logic [COUNT_WIDTH-1:0] pos;
			logic signed [15:0]     spd, e, dv;
			longint                 acc, act, mag;
			int                     s;
			tick_result_t           r;
			if (cmd == CMD_ENC) begin
				pos = position;
				if (a != prev_a)
					pos = (a ? b : !b) ? pos + 1'b1 : pos - 1'b1;
				if (b != prev_b)
					pos = (b ? !a : a) ? pos + 1'b1 : pos - 1'b1;
				position = pos;
				prev_a = a;
				prev_b = b;
				return;
			end
			spd = 16'(position - last_position);
			last_position = position;
			case (mode)
				MODE_RUN: begin
					e = setpoint - spd;
					dv = spd - prev_speed;
					acc = longint'(gain_p) * longint'(e) + longint'(gain_i) * longint'(error_sum)
						- longint'(gain_d) * longint'(dv);
					act = acc / 256;
					if (act > 32767)
						act = 32767;
					if (act < -32768)
						act = -32768;
					r.drive = (act > 0) ? DRV_FWD : DRV_BWD;
					mag = (act < 0) ? -act : act;
					if (mag > longint'(pwm_top))
						mag = longint'(pwm_top);
					drive_level = mag[9:0];
					s = int'(error_sum) + int'(e);
					if (s > int'(integral_limit))
						s = int'(integral_limit);
					else if (s < -int'(integral_limit))
						s = -int'(integral_limit);
					error_sum = s[13:0];
					held_error = e;
					prev_speed = spd;
				end
				MODE_HOLD: r.drive = DRV_KEEP;
				MODE_STOP: begin
					r.drive = DRV_BRAKE;
					drive_level = pwm_top;
				end
				default: begin
					r.drive = DRV_COAST;
					drive_level = '0;
				end
			endcase
			r.duty = drive_level;
			r.speed = spd;
			r.speed_error = held_error;
			r.integral = error_sum;
			owed.push_back(r);
		endfunction

		function void field_check(string name, logic signed [31:0] exp_v,
				logic signed [31:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(logic [9:0] duty, logic [2:0] drive,
				logic signed [15:0] speed, logic signed [15:0] speed_error,
				logic signed [13:0] integral);
			tick_result_t x;
			if (owed.size() == 0) begin
				$display("%0t result with none expected: expected nothing, actual duty %0d drive %0d",
					$time, duty, drive);
				errors++;
				return;
			end
			x = owed.pop_front();
			field_check("duty", x.duty, duty);
			field_check("drive", x.drive, drive);
			field_check("speed", x.speed, speed);
			field_check("speed_error", x.speed_error, speed_error);
			field_check("integral", x.integral, integral);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;

	qspc_item_if   item_ch();
	qspc_result_if result_ch();

	quadrature_speed_pid_motor_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	speed_loop_scoreboard model = new();
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;
	logic [1:0] gray_pos;
	logic dir_up;

	always #5 clk = ~clk;

	// result side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				model.check_result(result_ch.duty, result_ch.drive, result_ch.speed,
					result_ch.speed_error, result_ch.integral);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("quadrature_speed_pid_motor_controller regression: fail");
				$finish;
			end
		end
	end

	task automatic send_item(cmd_t cmd, logic a, logic b, logic signed [15:0] setpoint,
			mode_t mode);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= cmd;
		item_ch.enc_a <= a;
		item_ch.enc_b <= b;
		item_ch.setpoint <= setpoint;
		item_ch.mode <= mode;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		model.note_item(cmd, a, b, setpoint, mode);
	endtask

	task automatic send_enc(logic a, logic b);
		send_item(CMD_ENC, a, b, 16'($urandom), mode_t'($urandom_range(MODE_COAST)));
	endtask

	task automatic send_tick(logic signed [15:0] setpoint, mode_t mode);
		send_item(CMD_TICK, 1'($urandom), 1'($urandom), setpoint, mode);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (model.owed.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
			logic [15:0] pwm, logic [15:0] ilim);
		logic [15:0] vals[5];
		cfg_idx_t    r;
		vals = '{gp, gi, gd, pwm, ilim};
		r = r.first();
		cfg_we <= 1'b1;
		repeat (r.num()) begin
			cfg_idx <= r;
			cfg_data <= vals[r];
			@(posedge clk);
			model.write_reg(r, vals[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_setpoint();
		int k;
		k = $urandom_range(99);
		if (k < 60)
			return 16'($urandom_range(60)) - 16'sd30;
		if (k < 85)
			return 16'($urandom);
		case ($urandom_range(3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	// mostly clean quadrature motion with occasional reversals, repeats and glitches
	task automatic run_random(int n);
		int    until_tick;
		int    k;
		logic  a, b;
		mode_t m;
		until_tick = $urandom_range(3, 14);
		repeat (n) begin
			if (until_tick == 0) begin
				k = $urandom_range(99);
				m = (k < 70) ? MODE_RUN : (k < 80) ? MODE_HOLD : (k < 90) ? MODE_STOP : MODE_COAST;
				send_tick(pick_setpoint(), m);
				until_tick = $urandom_range(3, 14);
			end else begin
				k = $urandom_range(99);
				if (k < 10)
					dir_up = !dir_up;
				if (k < 85)
					gray_pos = dir_up ? gray_pos + 2'd1 : gray_pos - 2'd1;
				else if (k >= 93)
					gray_pos = 2'($urandom);
				a = gray_pos[1];
				b = gray_pos[1] ^ gray_pos[0];
				send_enc(a, b);
				until_tick--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_GAIN_P;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_ENC;
		item_ch.enc_a = 1'b0;
		item_ch.enc_b = 1'b0;
		item_ch.setpoint = '0;
		item_ch.mode = MODE_RUN;
		result_ch.ready = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		gray_pos = 2'd0;
		dir_up = 1'b1;
		send_idle_pct = 24;
		recv_idle_pct = 76;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero action, forward and reverse counting, both channels at once,
		// saturation both ways, every mode, encoder levels on ticks ignored
		send_tick(16'sd0, MODE_RUN);
		send_enc(1'b0, 1'b1);
		send_enc(1'b1, 1'b1);
		send_enc(1'b1, 1'b0);
		send_enc(1'b0, 1'b0);
		send_tick(16'sh7FFF, MODE_RUN);
		send_tick(16'sh8000, MODE_RUN);
		send_enc(1'b1, 1'b1);
		send_enc(1'b0, 1'b0);
		send_enc(1'b1, 1'b0);
		send_enc(1'b1, 1'b1);
		send_enc(1'b0, 1'b1);
		send_enc(1'b0, 1'b0);
		send_tick(-16'sd1, MODE_RUN);
		send_item(CMD_TICK, 1'b1, 1'b1, 16'sd5, MODE_HOLD);
		send_tick(16'sd7, MODE_STOP);
		send_tick(16'sd3, MODE_COAST);
		send_enc(1'b0, 1'b1);
		send_item(CMD_TICK, 1'b0, 1'b0, 16'sd2, MODE_RUN);
		send_enc(1'b1, 1'b1);
		send_tick(16'sd0, MODE_RUN);
		drain();

		write_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1023, 16'd8191);
		run_random(220);
		drain();

		send_idle_pct = 76;
		recv_idle_pct = 24;
		write_regs(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd0);
		run_random(100);
		drain();

		write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1023)),
			16'($urandom_range(60)));
		run_random(120);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_regs(16'd256, 16'd32, 16'($urandom_range(512)), 16'd1000, 16'd5000);
		// result side stalls while ticks keep coming, so the tick queue fills up
		hold_left = 150;
		repeat (24) send_tick(pick_setpoint(), MODE_RUN);
		run_random(220);
		drain();

		if (model.errors == 0)
			$display("quadrature_speed_pid_motor_controller regression: pass");
		else
			$display("quadrature_speed_pid_motor_controller regression: fail");
		$finish;
	end

endmodule
